// ===== sv/qni_pkg.sv =====
package qni_pkg;

    // Default component format: signed Q4.12.
    localparam int COMP_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 12;

    // Action codes carried with each quaternion.
    typedef enum logic [1:0] {
        ACT_NORMALIZE = 2'd0,
        ACT_CONJUGATE = 2'd1,
        ACT_INVERSE   = 2'd2,
        ACT_MAGNITUDE = 2'd3
    } t_action;

    // Cycles from an accepted start to its result strobe.
    // Three front stages (magnitudes, squares, sum), the root entry stage,
    // one stage per root bit, the divider entry stage, one stage per quotient
    // bit, and the output register.
    function automatic int qni_latency(input int cw, input int fb);
        return 3 + 1 + (cw + 1) + 1 + (2 * fb + 2) + 1;
    endfunction

endpackage

// ===== sv/quaternion_normalize_inverse_unit.sv =====
// Channel   Direction  Transfer condition     Payload
// command   in         start && !busy         i_action, i_in_x, i_in_y, i_in_z, i_in_w
// result    out        o_done (one cycle)     o_out_x..o_out_w, o_magnitude,
//                                             o_zero_norm, o_saturated
//
// One quaternion is accepted every cycle; busy is never raised.
// Each result passes from its start through three front stages, the root entry stage,
// COMP_WIDTH+1 square-root stages, the divider entry stage, 2*FRAC_BITS+2
// divider stages and the output register; the default format is Q4.12.
// Synchronous active-low reset clears the valid bits only.
// The receiver cannot stall, so the pipeline never holds.
module quaternion_normalize_inverse_unit #(
    parameter int COMP_WIDTH = qni_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qni_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [1:0]                   i_action,
    input  logic signed [COMP_WIDTH-1:0] i_in_x,
    input  logic signed [COMP_WIDTH-1:0] i_in_y,
    input  logic signed [COMP_WIDTH-1:0] i_in_z,
    input  logic signed [COMP_WIDTH-1:0] i_in_w,
    output logic                         o_done,
    output logic signed [COMP_WIDTH-1:0] o_out_x,
    output logic signed [COMP_WIDTH-1:0] o_out_y,
    output logic signed [COMP_WIDTH-1:0] o_out_z,
    output logic signed [COMP_WIDTH-1:0] o_out_w,
    output logic [COMP_WIDTH:0]          o_magnitude,
    output logic                         o_zero_norm,
    output logic                         o_saturated
);
    import qni_pkg::*;

    localparam int CW  = COMP_WIDTH;
    localparam int FB  = FRAC_BITS;
    localparam int SQW = 2 * CW;            // one square
    localparam int SW  = 2 * CW + 2;        // sum of four squares
    localparam int RW  = CW + 1;            // root width
    localparam int RMW = RW + 3;            // root remainder width
    localparam int QW  = 2 * FB + 2;        // quotient bits, one extra for rounding
    localparam int NW  = CW + 2 * FB + 1;   // scaled numerator
    localparam int EW  = (QW > RW) ? QW : RW;

    typedef struct packed {
        t_action              act;
        logic [3:0]           neg;
        logic [3:0][CW-1:0]   mag;
    } t_comp;

    typedef struct packed {
        t_comp                c;
        logic [SW-1:0]        sv;
        logic [RMW-1:0]       rem;
        logic [RW-1:0]        root;
        logic                 zero;
        logic [SW-1:0]        sum;
    } t_sqs;

    typedef struct packed {
        t_comp                c;
        logic [RW-1:0]        root;
        logic                 zero;
        logic [SW-1:0]        d;
        logic [3:0][SW-1:0]   rem;
        logic [3:0][QW-1:0]   low;
        logic [3:0][QW-1:0]   q;
    } t_dvs;

    logic                   r_a_vld;
    t_comp                  r_a;
    logic                   r_b_vld;
    t_comp                  r_b;
    logic [3:0][SQW-1:0]    r_b_sq;
    logic                   r_c_vld;
    t_comp                  r_c;
    logic [SW-1:0]          r_c_sum;
    logic                   r_s_vld [0:RW];
    t_sqs                   r_s     [0:RW];
    t_sqs                   n_s     [1:RW];
    logic                   r_d_vld [0:QW];
    t_dvs                   r_d     [0:QW];
    t_dvs                   n_d     [1:QW];
    t_dvs                   n_d0;
    logic [3:0][CW-1:0]     n_out;
    logic                   n_sat;

    // The block takes a new command every cycle.
    assign busy = 1'b0;

    // Stage A: split each component into sign and magnitude.
    always_ff @(posedge i_clk) begin
        logic [3:0][CW-1:0] v;
        v = {i_in_w, i_in_z, i_in_y, i_in_x};
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else begin
            r_a_vld <= start && !busy;
        end
        r_a.act <= t_action'(i_action);
        for (int i = 0; i < 4; i++) begin
            r_a.neg[i] <= v[i][CW-1];
            r_a.mag[i] <= v[i][CW-1] ? (~v[i] + CW'(1)) : v[i];
        end
    end

    // Stage B: four squares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else begin
            r_b_vld <= r_a_vld;
        end
        r_b <= r_a;
        for (int i = 0; i < 4; i++) begin
            r_b_sq[i] <= SQW'(r_a.mag[i]) * SQW'(r_a.mag[i]);
        end
    end

    // Stage C: exact sum of squares.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else begin
            r_c_vld <= r_b_vld;
        end
        r_c     <= r_b;
        r_c_sum <= SW'(r_b_sq[0]) + SW'(r_b_sq[1]) + SW'(r_b_sq[2]) + SW'(r_b_sq[3]);
    end

    // Square root entry: remainder and root start at zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_vld[0] <= 1'b0;
        end else begin
            r_s_vld[0] <= r_c_vld;
        end
        r_s[0].c    <= r_c;
        r_s[0].sv   <= r_c_sum;
        r_s[0].rem  <= '0;
        r_s[0].root <= '0;
        r_s[0].zero <= (r_c_sum == '0);
        r_s[0].sum  <= r_c_sum;
    end

    // Square root: one result bit per stage, two radicand bits brought in each time.
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        always_comb begin
            logic [RMW-1:0] t;
            logic [RMW-1:0] trial;
            t     = {r_s[k].rem[RMW-3:0], r_s[k].sv[SW-1:SW-2]};
            trial = RMW'({r_s[k].root, 2'b01});
            n_s[k+1]    = r_s[k];
            n_s[k+1].sv = {r_s[k].sv[SW-3:0], 2'b00};
            if (t >= trial) begin
                n_s[k+1].rem  = t - trial;
                n_s[k+1].root = {r_s[k].root[RW-2:0], 1'b1};
            end else begin
                n_s[k+1].rem  = t;
                n_s[k+1].root = {r_s[k].root[RW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_s_vld[k+1] <= 1'b0;
            end else begin
                r_s_vld[k+1] <= r_s_vld[k];
            end
            r_s[k+1] <= n_s[k+1];
        end
    end

    // Divider entry: pick divisor and numerator scaling from the action.
    always_comb begin
        logic [NW-1:0] num;
        n_d0      = '0;
        n_d0.c    = r_s[RW].c;
        n_d0.root = r_s[RW].root;
        n_d0.zero = r_s[RW].zero;
        n_d0.d    = (r_s[RW].c.act == ACT_INVERSE) ? r_s[RW].sum : SW'(r_s[RW].root);
        for (int i = 0; i < 4; i++) begin
            if (r_s[RW].c.act == ACT_INVERSE) begin
                num = NW'(r_s[RW].c.mag[i]) << (2 * FB + 1);
            end else begin
                num = NW'(r_s[RW].c.mag[i]) << (FB + 1);
            end
            n_d0.rem[i] = SW'(num >> QW);
            n_d0.low[i] = num[QW-1:0];
            n_d0.q[i]   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else begin
            r_d_vld[0] <= r_s_vld[RW];
        end
        r_d[0] <= n_d0;
    end

    // Restoring division: one quotient bit per stage in each of four lanes.
    for (genvar k = 0; k < QW; k++) begin : g_div
        always_comb begin
            logic [SW:0] t;
            n_d[k+1] = r_d[k];
            for (int i = 0; i < 4; i++) begin
                t = {r_d[k].rem[i], r_d[k].low[i][QW-1]};
                n_d[k+1].low[i] = {r_d[k].low[i][QW-2:0], 1'b0};
                if (t >= {1'b0, r_d[k].d}) begin
                    n_d[k+1].rem[i] = SW'(t - {1'b0, r_d[k].d});
                    n_d[k+1].q[i]   = {r_d[k].q[i][QW-2:0], 1'b1};
                end else begin
                    n_d[k+1].rem[i] = t[SW-1:0];
                    n_d[k+1].q[i]   = {r_d[k].q[i][QW-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[k+1] <= 1'b0;
            end else begin
                r_d_vld[k+1] <= r_d_vld[k];
            end
            r_d[k+1] <= n_d[k+1];
        end
    end

    // Round, apply signs and clip to the component range; magnitude-only commands and zero norms give zero components.
    always_comb begin
        logic [QW:0]   qr;
        logic [EW-1:0] v;
        logic [EW-1:0] half;
        logic          n;
        half  = EW'(1) << (CW - 1);
        n_sat = 1'b0;
        n_out = '0;
        for (int i = 0; i < 4; i++) begin
            qr = ({1'b0, r_d[QW].q[i]} + (QW + 1)'(1)) >> 1;
            case (r_d[QW].c.act)
                ACT_NORMALIZE: begin
                    v = EW'(qr);
                    n = r_d[QW].c.neg[i];
                end
                ACT_CONJUGATE: begin
                    v = EW'(r_d[QW].c.mag[i]);
                    n = (i < 3) ? !r_d[QW].c.neg[i] : r_d[QW].c.neg[i];
                end
                ACT_INVERSE: begin
                    v = EW'(qr);
                    n = (i < 3) ? !r_d[QW].c.neg[i] : r_d[QW].c.neg[i];
                end
                default: begin
                    v = '0;
                    n = 1'b0;
                end
            endcase
            if (v == '0) begin
                n = 1'b0;
            end
            if (n && (v > half)) begin
                v     = half;
                n_sat = 1'b1;
            end else if (!n && (v > half - EW'(1))) begin
                v     = half - EW'(1);
                n_sat = 1'b1;
            end
            n_out[i] = n ? (~v[CW-1:0] + CW'(1)) : v[CW-1:0];
        end
        if (r_d[QW].zero) begin
            n_out = '0;
            n_sat = 1'b0;
        end
    end

    // Output register and result strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_d_vld[QW];
        end
        o_out_x     <= n_out[0];
        o_out_y     <= n_out[1];
        o_out_z     <= n_out[2];
        o_out_w     <= n_out[3];
        o_magnitude <= r_d[QW].root;
        o_zero_norm <= r_d[QW].zero;
        o_saturated <= n_sat;
    end

endmodule

// ===== sv/qni_checker.sv =====
module qni_checker #(
    parameter int COMP_WIDTH = qni_pkg::COMP_WIDTH_DEF,
    parameter int FRAC_BITS  = qni_pkg::FRAC_BITS_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [1:0]                   i_action,
    input logic signed [COMP_WIDTH-1:0] i_in_x,
    input logic signed [COMP_WIDTH-1:0] i_in_y,
    input logic signed [COMP_WIDTH-1:0] i_in_z,
    input logic signed [COMP_WIDTH-1:0] i_in_w,
    input logic                         o_done,
    input logic signed [COMP_WIDTH-1:0] o_out_x,
    input logic signed [COMP_WIDTH-1:0] o_out_y,
    input logic signed [COMP_WIDTH-1:0] o_out_z,
    input logic signed [COMP_WIDTH-1:0] o_out_w,
    input logic [COMP_WIDTH:0]          o_magnitude,
    input logic                         o_zero_norm,
    input logic                         o_saturated
);
    import qni_pkg::*;

    localparam int LAT = qni_latency(COMP_WIDTH, FRAC_BITS);

    // Every result strobe comes from an earlier command transfer.
    a_done_has_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result strobe without matching command");

    // A zero norm yields zero components, zero magnitude and no clipping.
    a_zero_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_zero_norm) |-> (o_out_x == '0 && o_out_y == '0 && o_out_z == '0
            && o_out_w == '0 && o_magnitude == '0 && !o_saturated))
        else $error("zero norm result not cleared");

    // A zero magnitude only comes from an all-zero quaternion.
    a_zero_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_magnitude == '0) |-> o_zero_norm)
        else $error("zero magnitude without zero norm flag");

    // Magnitude-only commands give zero components and no clipping.
    a_mag_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(i_action == ACT_MAGNITUDE, LAT)) |-> (o_out_x == '0
            && o_out_y == '0 && o_out_z == '0 && o_out_w == '0 && !o_saturated))
        else $error("magnitude-only result carries components");

endmodule

bind quaternion_normalize_inverse_unit qni_checker #(
    .COMP_WIDTH(COMP_WIDTH),
    .FRAC_BITS (FRAC_BITS)
) u_qni_checker (.*);
